// ----- rtl/pesp_pkg.sv -----
// Shared types and constants of the printer escape sequence parser.
package pesp_pkg;

	localparam logic [2:0] COUNT_DIGITS = 3'd4;
	localparam logic [2:0] PITCH_DIGITS = 3'd2;

	localparam int unsigned ARG_W = 14;

	typedef enum logic [4:0] {
		MODE_TEXT = 5'b00001,
		MODE_CODE = 5'b00010,
		MODE_ARG  = 5'b00100,
		MODE_DATA = 5'b01000,
		MODE_SKIP = 5'b10000
	} mode_t;

	typedef enum logic [2:0] {
		ACT_CHAR    = 3'd0,
		ACT_LPI     = 3'd1,
		ACT_CPI     = 3'd2,
		ACT_DPI     = 3'd3,
		ACT_HALF_PT = 3'd4,
		ACT_GFX     = 3'd5
	} action_t;

	localparam logic [6:0] CH_ESC   = 7'h1B;
	localparam logic [6:0] CH_TAB   = 7'h09;
	localparam logic [6:0] CH_CR    = 7'h0D;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_NINE  = 7'h39;

	localparam logic [6:0] CODE_NOP   = 7'h3E;
	localparam logic [6:0] CODE_A     = 7'h41;
	localparam logic [6:0] CODE_B     = 7'h42;
	localparam logic [6:0] CODE_LO_E  = 7'h65;
	localparam logic [6:0] CODE_E     = 7'h45;
	localparam logic [6:0] CODE_LO_N  = 7'h6E;
	localparam logic [6:0] CODE_N     = 7'h4E;
	localparam logic [6:0] CODE_LO_P  = 7'h70;
	localparam logic [6:0] CODE_P     = 7'h50;
	localparam logic [6:0] CODE_LO_Q  = 7'h71;
	localparam logic [6:0] CODE_Q     = 7'h51;
	localparam logic [6:0] CODE_G     = 7'h47;
	localparam logic [6:0] CODE_S     = 7'h53;
	localparam logic [6:0] CODE_T     = 7'h54;

	typedef struct packed {
		logic [ARG_W-1:0] value;
		logic             begun;
		logic             neg;
		logic             stopped;
	} arg_state_t;

endpackage

// ----- rtl/pesp_if.sv -----
// Valid/ready channels for input bytes and parser results.
interface pesp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface pesp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

// ----- rtl/pesp_arg.sv -----
// Next-state logic of the atoi-style argument accumulator.
module pesp_arg (
	input  pesp_pkg::arg_state_t cur,
	input  logic [6:0]           ch,
	output pesp_pkg::arg_state_t nxt
);

	logic [pesp_pkg::ARG_W-1:0] digit;

	assign digit = pesp_pkg::ARG_W'(ch - pesp_pkg::CH_ZERO);

	always_comb begin
		nxt = cur;
		if (!cur.stopped) begin
			if (ch inside {[pesp_pkg::CH_ZERO:pesp_pkg::CH_NINE]}) begin
				nxt.value = pesp_pkg::ARG_W'(cur.value * 4'd10) + digit;
				nxt.begun = 1'b1;
			end else if (!cur.begun
				&& (ch inside {pesp_pkg::CH_SPACE, [pesp_pkg::CH_TAB:pesp_pkg::CH_CR]})) begin
				nxt = cur;
			end else if (!cur.begun
				&& (ch inside {pesp_pkg::CH_PLUS, pesp_pkg::CH_MINUS})) begin
				nxt.begun = 1'b1;
				nxt.neg   = (ch == pesp_pkg::CH_MINUS);
			end else begin
				nxt.stopped = 1'b1;
			end
		end
	end

endmodule

// ----- rtl/printer_escape_sequence_parser.sv -----
// Printer escape sequence parser: mode tracking, argument parsing, result register.
// Results are registered: a result appears on the result channel in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless input is stalled; the mode and argument state update on each accepted byte.
// Input ready drops only while the result register holds an item that is not taken.
// Reset (arst_n low, asynchronous) enters text mode and clears the argument and counters.
module printer_escape_sequence_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	pesp_byte_if.sink            host,
	pesp_result_if.source        result
);

	pesp_pkg::mode_t            mode_q, mode_d;
	logic [6:0]                 cmd_q, cmd_d;
	pesp_pkg::arg_state_t       arg_q, arg_d, arg_fed;
	logic [2:0]                 seen_q, seen_d, seen_inc;
	logic [pesp_pkg::ARG_W-1:0] left_q, left_d, left_dec;
	logic                       emit;
	pesp_pkg::action_t          emit_act;
	logic [7:0]                 emit_val;
	logic                       res_valid_q;
	pesp_pkg::action_t          res_act_q;
	logic [7:0]                 res_val_q;
	logic                       accept;
	logic [6:0]                 low;
	logic                       pitch;
	logic [2:0]                 need;

	assign host.ready = !res_valid_q || result.ready;
	assign accept     = host.valid && host.ready;
	assign low        = host.data_byte[6:0];
	assign pitch      = (cmd_q == pesp_pkg::CODE_T);
	assign need       = pitch ? pesp_pkg::PITCH_DIGITS : pesp_pkg::COUNT_DIGITS;
	assign seen_inc   = seen_q + 3'd1;
	assign left_dec   = (left_q != '0) ? left_q - 1'b1 : left_q;

	pesp_arg u_arg (
		.cur (arg_q),
		.ch  (low),
		.nxt (arg_fed)
	);

	always_comb begin
		mode_d   = mode_q;
		cmd_d    = cmd_q;
		arg_d    = arg_q;
		seen_d   = seen_q;
		left_d   = left_q;
		emit     = 1'b0;
		emit_act = pesp_pkg::ACT_CHAR;
		emit_val = host.data_byte;
		case (mode_q)
			pesp_pkg::MODE_CODE: begin
				cmd_d  = low;
				mode_d = pesp_pkg::MODE_TEXT;
				case (low)
					pesp_pkg::CODE_NOP: emit = 1'b0;
					pesp_pkg::CODE_A: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_LPI; emit_val = 8'd6;
					end
					pesp_pkg::CODE_B: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_LPI; emit_val = 8'd8;
					end
					pesp_pkg::CODE_LO_E: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_DPI; emit_val = 8'd107;
					end
					pesp_pkg::CODE_E: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd12;
					end
					pesp_pkg::CODE_LO_N: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd9;
					end
					pesp_pkg::CODE_N: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd10;
					end
					pesp_pkg::CODE_LO_P: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd18;
					end
					pesp_pkg::CODE_P: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd20;
					end
					pesp_pkg::CODE_LO_Q: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd15;
					end
					pesp_pkg::CODE_Q: begin
						emit = 1'b1; emit_act = pesp_pkg::ACT_CPI; emit_val = 8'd17;
					end
					pesp_pkg::CODE_G, pesp_pkg::CODE_S, pesp_pkg::CODE_T: begin
						mode_d = pesp_pkg::MODE_ARG;
						arg_d  = '0;
						seen_d = '0;
					end
					default: mode_d = pesp_pkg::MODE_SKIP;
				endcase
			end
			pesp_pkg::MODE_ARG: begin
				arg_d  = arg_fed;
				seen_d = seen_inc;
				if (seen_inc >= need) begin
					mode_d = pesp_pkg::MODE_TEXT;
					if (!arg_fed.neg && arg_fed.value != '0) begin
						if (pitch) begin
							emit     = 1'b1;
							emit_act = pesp_pkg::ACT_HALF_PT;
							emit_val = (arg_fed.value > pesp_pkg::ARG_W'(255))
								? 8'hFF : arg_fed.value[7:0];
						end else begin
							left_d = arg_fed.value;
							mode_d = pesp_pkg::MODE_DATA;
						end
					end
				end
			end
			pesp_pkg::MODE_DATA: begin
				left_d   = left_dec;
				emit     = 1'b1;
				emit_act = pesp_pkg::ACT_GFX;
				if (left_dec == '0) begin
					mode_d = pesp_pkg::MODE_TEXT;
				end
			end
			pesp_pkg::MODE_SKIP: begin
				if (low == pesp_pkg::CH_ESC) begin
					mode_d = pesp_pkg::MODE_CODE;
				end
			end
			default: begin
				mode_d = pesp_pkg::MODE_TEXT;
				if (low == pesp_pkg::CH_ESC) begin
					mode_d = pesp_pkg::MODE_CODE;
				end else begin
					emit = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= pesp_pkg::MODE_TEXT;
			cmd_q       <= '0;
			arg_q       <= '0;
			seen_q      <= '0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_d;
				cmd_q       <= cmd_d;
				arg_q       <= arg_d;
				seen_q      <= seen_d;
				left_q      <= left_d;
				res_valid_q <= emit;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_act_q <= emit_act;
			res_val_q <= emit_val;
		end
	end

	assign result.valid  = res_valid_q;
	assign result.action = res_act_q;
	assign result.value  = res_val_q;

`ifndef SYNTH
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == pesp_pkg::MODE_DATA |-> left_q != '0)
		else $error("data mode with no bytes left");

	a_arg_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == pesp_pkg::MODE_ARG |-> seen_q < need)
		else $error("argument overran its length");

	a_gfx_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q == pesp_pkg::MODE_DATA
		|=> res_valid_q && res_act_q == pesp_pkg::ACT_GFX)
		else $error("graphics byte not emitted");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> host.ready)
		else $error("input stalled with empty result register");
`endif

endmodule
